FILE: rtl/mips_style_alu_register_file_macros.svh
// Assertion macros shared by the RTL. Each check is sampled on clk and
// switched off while arst_n is low.
`ifndef MIPS_STYLE_ALU_REGISTER_FILE_MACROS_SVH
`define MIPS_STYLE_ALU_REGISTER_FILE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MALU_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("malu check failed");

// The consequent must hold in the cycle after the antecedent.
`define MALU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("malu check failed");

`endif

FILE: rtl/malu_pkg.sv
package malu_pkg;

	localparam int unsigned DATA_W = 32;
	localparam int unsigned IDX_W = 5;
	localparam int unsigned IMM_W = 16;
	localparam int unsigned PROD_W = 2 * DATA_W;

	typedef enum logic [3:0] {
		CMD_ADD   = 4'd0,
		CMD_ADDU  = 4'd1,
		CMD_SUB   = 4'd2,
		CMD_AND   = 4'd3,
		CMD_OR    = 4'd4,
		CMD_XOR   = 4'd5,
		CMD_NOR   = 4'd6,
		CMD_NAND  = 4'd7,
		CMD_SLT   = 4'd8,
		CMD_SLL   = 4'd9,
		CMD_SRL   = 4'd10,
		CMD_SRA   = 4'd11,
		CMD_MULT  = 4'd12,
		CMD_MULTU = 4'd13,
		CMD_ADDI  = 4'd14,
		CMD_ADDIU = 4'd15
	} cmd_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_EXEC,
		ST_WB
	} state_t;

endpackage

FILE: rtl/mips_style_alu_register_file.sv
// Integer execution unit with a register file and HI/LO registers. One
// instruction is taken per transaction and each yields exactly one result
// transaction. An instruction passes through these steps in order: on
// acceptance both source registers are read from the two-read-port register
// file memory, then the ALU result and the 32x32 product are registered, and
// last, once the output register can be loaded, the register file or HI/LO is
// written and the output register is loaded. No new instruction is accepted
// until the previous one has been written back. A finished result may wait in
// the output register while the next instruction is accepted.
// Every register reads as zero after reset, through per-entry valid bits; an
// index at or above REGISTER_COUNT reads as zero and is never written.
module mips_style_alu_register_file
	import malu_pkg::*;
#(
	parameter int unsigned REGISTER_COUNT = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  logic [3:0]          command,
	input  logic [IDX_W-1:0]    source_index,
	input  logic [IDX_W-1:0]    second_index,
	input  logic [IDX_W-1:0]    dest_index,
	input  logic [IDX_W-1:0]    shift_amount,
	input  logic [IMM_W-1:0]    immediate,
	output logic                out_valid,
	input  logic                out_stall,
	output logic                wrote_register,
	output logic [IDX_W-1:0]    written_index,
	output logic [DATA_W-1:0]   written_value,
	output logic                overflow,
	output logic [DATA_W-1:0]   hi_value,
	output logic [DATA_W-1:0]   lo_value
);

	`include "mips_style_alu_register_file_macros.svh"

	localparam int unsigned AW = (REGISTER_COUNT > 1) ? $clog2(REGISTER_COUNT) : 1;
	localparam int unsigned WIDE_W = 7;

	state_t state_q, state_d;

	logic [DATA_W-1:0] mem [REGISTER_COUNT];
	logic [REGISTER_COUNT-1:0] valid_q;

	logic in_fire;
	logic wb_fire;
	logic out_load;

	logic [WIDE_W-1:0] rs_wide, rt_wide, dst_wide;
	logic [AW-1:0] rs_addr, rt_addr, dst_addr;
	logic rs_ok, rt_ok, dst_ok;

	logic [DATA_W-1:0] rs_data_s1, rt_data_s1;
	logic rs_live_s1, rt_live_s1;
	cmd_t cmd_s1;
	logic [IDX_W-1:0] rt_idx_s1, rd_idx_s1, sh_s1;
	logic [IMM_W-1:0] imm_s1;

	logic [DATA_W-1:0] op_a, op_b, simm;
	logic [DATA_W-1:0] sum_ab, diff_ab, sum_ai;
	logic [DATA_W-1:0] alu_val;
	logic alu_ovf, alu_writes, alu_mul;
	logic [IDX_W-1:0] alu_dst;
	logic signed [DATA_W:0] mul_a, mul_b;
	logic signed [2*DATA_W+1:0] mul_full;

	logic [DATA_W-1:0] val_s2;
	logic ovf_s2, writes_s2, mul_s2;
	logic [IDX_W-1:0] dst_s2;
	logic [PROD_W-1:0] prod_s2;

	logic [DATA_W-1:0] hi_q, lo_q, hi_next, lo_next;
	logic wr_en;

	logic out_valid_q;
	logic wrote_q, ovf_q;
	logic [IDX_W-1:0] widx_q;
	logic [DATA_W-1:0] wval_q, hi_out_q, lo_out_q;

	assign in_fire = in_valid && !in_stall;
	assign out_load = !out_valid_q || !out_stall;
	assign wb_fire = (state_q == ST_WB) && out_load;

	assign rs_wide = {{(WIDE_W - IDX_W){1'b0}}, source_index};
	assign rt_wide = {{(WIDE_W - IDX_W){1'b0}}, second_index};
	assign dst_wide = {{(WIDE_W - IDX_W){1'b0}}, dst_s2};
	assign rs_addr = rs_wide[AW-1:0];
	assign rt_addr = rt_wide[AW-1:0];
	assign dst_addr = dst_wide[AW-1:0];
	assign rs_ok = rs_wide < WIDE_W'(REGISTER_COUNT);
	assign rt_ok = rt_wide < WIDE_W'(REGISTER_COUNT);
	assign dst_ok = dst_wide < WIDE_W'(REGISTER_COUNT);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		in_stall = 1'b1;
		unique case (state_q)
			ST_IDLE: begin
				in_stall = 1'b0;
				if (in_valid) begin
					state_d = ST_EXEC;
				end
			end
			ST_EXEC: begin
				state_d = ST_WB;
			end
			ST_WB: begin
				if (out_load) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rs_data_s1 <= mem[rs_addr];
			rt_data_s1 <= mem[rt_addr];
		end
		if (wb_fire && wr_en) begin
			mem[dst_addr] <= val_s2;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
		end else if (wb_fire && wr_en) begin
			valid_q[dst_addr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			rs_live_s1 <= rs_ok && valid_q[rs_addr];
			rt_live_s1 <= rt_ok && valid_q[rt_addr];
			cmd_s1 <= cmd_t'(command);
			rt_idx_s1 <= second_index;
			rd_idx_s1 <= dest_index;
			sh_s1 <= shift_amount;
			imm_s1 <= immediate;
		end
	end

	assign op_a = rs_live_s1 ? rs_data_s1 : '0;
	assign op_b = rt_live_s1 ? rt_data_s1 : '0;
	assign simm = {{(DATA_W - IMM_W){imm_s1[IMM_W-1]}}, imm_s1};
	assign sum_ab = op_a + op_b;
	assign diff_ab = op_a - op_b;
	assign sum_ai = op_a + simm;

	assign mul_a = {(cmd_s1 == CMD_MULT) && op_a[DATA_W-1], op_a};
	assign mul_b = {(cmd_s1 == CMD_MULT) && op_b[DATA_W-1], op_b};
	assign mul_full = mul_a * mul_b;

	always_comb begin
		alu_val = '0;
		alu_ovf = 1'b0;
		alu_writes = 1'b1;
		alu_mul = 1'b0;
		alu_dst = rd_idx_s1;
		unique case (cmd_s1) inside
			CMD_ADD: begin
				alu_val = sum_ab;
				alu_ovf = (op_a[DATA_W-1] ^ sum_ab[DATA_W-1])
					& (op_b[DATA_W-1] ^ sum_ab[DATA_W-1]);
			end
			CMD_ADDU: alu_val = sum_ab;
			CMD_SUB: begin
				alu_val = diff_ab;
				alu_ovf = (op_a[DATA_W-1] ^ op_b[DATA_W-1])
					& (op_a[DATA_W-1] ^ diff_ab[DATA_W-1]);
			end
			CMD_AND: alu_val = op_a & op_b;
			CMD_OR: alu_val = op_a | op_b;
			CMD_XOR: alu_val = op_a ^ op_b;
			CMD_NOR: alu_val = ~(op_a | op_b);
			CMD_NAND: alu_val = ~(op_a & op_b);
			CMD_SLT: alu_val = {{(DATA_W - 1){1'b0}}, ($signed(op_a) < $signed(op_b))};
			CMD_SLL: alu_val = op_b << sh_s1;
			CMD_SRL: alu_val = op_b >> sh_s1;
			CMD_SRA: alu_val = DATA_W'($signed(op_b) >>> sh_s1);
			CMD_MULT, CMD_MULTU: begin
				alu_writes = 1'b0;
				alu_mul = 1'b1;
				alu_dst = '0;
			end
			CMD_ADDI: begin
				alu_val = sum_ai;
				alu_ovf = (op_a[DATA_W-1] ^ sum_ai[DATA_W-1])
					& (simm[DATA_W-1] ^ sum_ai[DATA_W-1]);
				alu_dst = rt_idx_s1;
			end
			CMD_ADDIU: begin
				alu_val = sum_ai;
				alu_dst = rt_idx_s1;
			end
			default: begin
				alu_val = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_EXEC) begin
			val_s2 <= alu_val;
			ovf_s2 <= alu_ovf;
			writes_s2 <= alu_writes;
			mul_s2 <= alu_mul;
			dst_s2 <= alu_dst;
			prod_s2 <= mul_full[PROD_W-1:0];
		end
	end

	assign wr_en = writes_s2 && dst_ok;
	assign hi_next = mul_s2 ? prod_s2[PROD_W-1:DATA_W] : hi_q;
	assign lo_next = mul_s2 ? prod_s2[DATA_W-1:0] : lo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hi_q <= '0;
			lo_q <= '0;
		end else if (wb_fire) begin
			hi_q <= hi_next;
			lo_q <= lo_next;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (wb_fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (wb_fire) begin
			wrote_q <= wr_en;
			widx_q <= dst_s2;
			wval_q <= val_s2;
			ovf_q <= ovf_s2;
			hi_out_q <= hi_next;
			lo_out_q <= lo_next;
		end
	end

	assign out_valid = out_valid_q;
	assign wrote_register = wrote_q;
	assign written_index = widx_q;
	assign written_value = wval_q;
	assign overflow = ovf_q;
	assign hi_value = hi_out_q;
	assign lo_value = lo_out_q;

	`MALU_ASSERT_NEXT(a_accept_to_exec, in_fire, state_q == ST_EXEC)
	`MALU_ASSERT_NEXT(a_wb_loads_output, wb_fire, out_valid_q && state_q == ST_IDLE)
	`MALU_ASSERT_SAME(a_hilo_only_at_wb, !$stable(hi_q) || !$stable(lo_q), $past(state_q) == ST_WB)
	`MALU_ASSERT_SAME(a_mul_no_write, (state_q == ST_WB) && mul_s2, !wr_en && dst_s2 == '0)

endmodule
